// ===== rtl/tnp_pkg.sv =====
// ----------------------------------------------------------------------------
// tnp_pkg: shared types and constants for the telnet option parser
// Telnet command codes, event kinds, parse phase encoding and the
// structs that carry a request and an event between the parser stages.
// ----------------------------------------------------------------------------
package tnp_pkg;

  // Telnet protocol codes
  localparam logic [7:0] CodeIac  = 8'd255;
  localparam logic [7:0] CodeSe   = 8'd240;
  localparam logic [7:0] CodeSb   = 8'd250;
  localparam logic [7:0] CodeWill = 8'd251;
  localparam logic [7:0] CodeWont = 8'd252;
  localparam logic [7:0] CodeDo   = 8'd253;
  localparam logic [7:0] CodeDont = 8'd254;
  localparam logic [7:0] OptNaws  = 8'd31;

  // Printable range
  localparam logic [7:0] PrintLo = 8'h21;
  localparam logic [7:0] PrintHi = 8'h7E;

  // Default subnegotiation body limit
  localparam int unsigned BodyLimitDefault = 256;

  // Number of window-size body bytes
  localparam int unsigned NawsBytes = 4;

  typedef enum logic [2:0] {
    EV_CHAR  = 3'd0,
    EV_CMD   = 3'd1,
    EV_WILL  = 3'd2,
    EV_WONT  = 3'd3,
    EV_WINSZ = 3'd4
  } ev_kind_e;

  typedef enum logic [7:0] {
    PH_IDLE      = 8'b0000_0001,
    PH_AFTER_IAC = 8'b0000_0010,
    PH_WILL      = 8'b0000_0100,
    PH_WONT      = 8'b0000_1000,
    PH_DO        = 8'b0001_0000,
    PH_DONT      = 8'b0010_0000,
    PH_SB_OPTION = 8'b0100_0000,
    PH_SB_BODY   = 8'b1000_0000
  } phase_e;

  // One registered request handed to the parser
  typedef struct packed {
    logic       fire;
    logic [7:0] rx_byte;
  } req_t;

  // One parser event
  typedef struct packed {
    ev_kind_e    kind;
    logic [7:0]  ev_byte;
    logic [15:0] width;
    logic [15:0] height;
  } event_t;

endpackage

// ===== rtl/tnp_in_reg.sv =====
// ----------------------------------------------------------------------------
// tnp_in_reg: input request register
// Holds one received byte; frees itself whenever the parser advances.
// ----------------------------------------------------------------------------
module tnp_in_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rx_valid_i,
  output logic          rx_ready_o,
  input  logic [7:0]    rx_byte_i,
  input  logic          out_free_i,
  output tnp_pkg::req_t req_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       advance;

  assign advance    = valid_q & out_free_i;
  assign rx_ready_o = ~valid_q | advance;

  always_comb begin
    valid_d = valid_q;
    if (rx_ready_o) begin
      valid_d = rx_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_ready_o && rx_valid_i) begin
      byte_q <= rx_byte_i;
    end
  end

  assign req_o.fire    = advance;
  assign req_o.rx_byte = byte_q;

endmodule

// ===== rtl/tnp_fsm.sv =====
// ----------------------------------------------------------------------------
// tnp_fsm: telnet command state machine
// Tracks the IAC phase, counts subnegotiation body bytes and builds the
// window-size event from the first four body bytes.
// ----------------------------------------------------------------------------
module tnp_fsm #(
  parameter int unsigned BodyLimit = tnp_pkg::BodyLimitDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tnp_pkg::req_t   req_i,
  output logic            ev_valid_o,
  output tnp_pkg::event_t ev_o
);

  localparam int unsigned CntW = $clog2(BodyLimit + 1);

  tnp_pkg::phase_e phase_q, phase_d;
  logic [CntW-1:0] count_q, count_d;
  logic            iac_seen_q, iac_seen_d;
  logic            naws_q, naws_d;
  logic [7:0]      size_q [3];
  logic            size_we;
  logic [7:0]      c;

  assign c       = req_i.rx_byte;
  assign size_we = (phase_q == tnp_pkg::PH_SB_BODY) &&
                   (count_q < CntW'(BodyLimit)) && (count_q < CntW'(3));

  always_comb begin
    phase_d    = phase_q;
    count_d    = count_q;
    iac_seen_d = iac_seen_q;
    naws_d     = naws_q;
    ev_valid_o = 1'b0;
    ev_o       = '0;
    ev_o.ev_byte = c;

    unique case (phase_q)
      tnp_pkg::PH_IDLE: begin
        if (c == tnp_pkg::CodeIac) begin
          phase_d = tnp_pkg::PH_AFTER_IAC;
        end else if (c >= tnp_pkg::PrintLo && c <= tnp_pkg::PrintHi) begin
          ev_valid_o = 1'b1;
          ev_o.kind  = tnp_pkg::EV_CHAR;
        end
      end
      tnp_pkg::PH_AFTER_IAC: begin
        ev_valid_o = 1'b1;
        ev_o.kind  = tnp_pkg::EV_CMD;
        case (c)
          tnp_pkg::CodeWill: phase_d = tnp_pkg::PH_WILL;
          tnp_pkg::CodeWont: phase_d = tnp_pkg::PH_WONT;
          tnp_pkg::CodeDo:   phase_d = tnp_pkg::PH_DO;
          tnp_pkg::CodeDont: phase_d = tnp_pkg::PH_DONT;
          tnp_pkg::CodeSb:   phase_d = tnp_pkg::PH_SB_OPTION;
          default:           phase_d = tnp_pkg::PH_IDLE;
        endcase
      end
      tnp_pkg::PH_WILL: begin
        phase_d    = tnp_pkg::PH_IDLE;
        ev_valid_o = 1'b1;
        ev_o.kind  = tnp_pkg::EV_WILL;
      end
      tnp_pkg::PH_WONT: begin
        phase_d    = tnp_pkg::PH_IDLE;
        ev_valid_o = 1'b1;
        ev_o.kind  = tnp_pkg::EV_WONT;
      end
      tnp_pkg::PH_SB_OPTION: begin
        phase_d    = tnp_pkg::PH_SB_BODY;
        count_d    = '0;
        iac_seen_d = 1'b0;
        naws_d     = (c == tnp_pkg::OptNaws);
      end
      tnp_pkg::PH_SB_BODY: begin
        if (count_q >= CntW'(BodyLimit)) begin
          // body overflow: drop the byte
          phase_d = tnp_pkg::PH_IDLE;
        end else begin
          count_d = count_q + CntW'(1);
          if (!iac_seen_q) begin
            iac_seen_d = (c == tnp_pkg::CodeIac);
          end else if (c == tnp_pkg::CodeSe) begin
            phase_d = tnp_pkg::PH_IDLE;
          end else begin
            iac_seen_d = 1'b0;
          end
          if (naws_q && count_q == CntW'(tnp_pkg::NawsBytes - 1)) begin
            naws_d       = 1'b0;
            ev_valid_o   = 1'b1;
            ev_o.kind    = tnp_pkg::EV_WINSZ;
            ev_o.ev_byte = '0;
            ev_o.width   = {size_q[0], size_q[1]};
            ev_o.height  = {size_q[2], c};
          end
        end
      end
      // DO / DONT option bytes are swallowed
      default: begin
        phase_d = tnp_pkg::PH_IDLE;
      end
    endcase

    if (!req_i.fire) begin
      ev_valid_o = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= tnp_pkg::PH_IDLE;
      count_q    <= '0;
      iac_seen_q <= 1'b0;
      naws_q     <= 1'b0;
    end else if (req_i.fire) begin
      phase_q    <= phase_d;
      count_q    <= count_d;
      iac_seen_q <= iac_seen_d;
      naws_q     <= naws_d;
    end
  end

  // first three body bytes; the fourth is taken straight from the request
  always_ff @(posedge clk_i) begin
    if (req_i.fire && size_we) begin
      size_q[count_q[1:0]] <= c;
    end
  end

endmodule

// ===== rtl/tnp_out_reg.sv =====
// ----------------------------------------------------------------------------
// tnp_out_reg: result register
// Holds one event until the consumer takes it.
// ----------------------------------------------------------------------------
module tnp_out_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  logic            ev_valid_i,
  input  tnp_pkg::event_t ev_i,
  output logic            free_o,
  output logic            event_valid_o,
  input  logic            event_ready_i,
  output tnp_pkg::event_t ev_o
);

  logic            valid_q, valid_d;
  tnp_pkg::event_t ev_q;

  assign free_o = ~valid_q | event_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = ev_valid_i;
    end else if (event_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && ev_valid_i) begin
      ev_q <= ev_i;
    end
  end

  assign event_valid_o = valid_q;
  assign ev_o          = ev_q;

endmodule

// ===== rtl/telnet_option_parser.sv =====
// ----------------------------------------------------------------------------
// telnet_option_parser: telnet IAC option parser with window-size decode
// Parses a received telnet byte stream and reports characters, commands,
// WILL/WONT options and the window size from a NAWS subnegotiation.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                   | payload
//  --------+-----------+-----------------------------+--------------------------
//  rx      | in        | rx_valid_i / rx_ready_o     | rx_byte_i
//  event   | out       | event_valid_o / event_ready_i | event_kind_o, event_byte_o,
//          |           |                             | window_width_o, window_height_o
//
//  Cycles: one byte per cycle sustained while events are taken. A byte is
//  registered on accept and parsed once the result register is free; its
//  event (if any) is loaded into the result register as the parse step ends.
//  The parse step is a single pass through the phase decode and body counter.
//  Stalls: rx_ready_o stays high while the result register is free or being
//  drained; a held event stalls the parse stage, which then fills the input
//  register and deasserts rx_ready_o.
//  Reset: asynchronous, active low; the parser returns to idle with an empty
//  pipeline. No clearing pass is needed.
//
module telnet_option_parser #(
  parameter int unsigned BodyLimit = tnp_pkg::BodyLimitDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        rx_valid_i,
  output logic        rx_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        event_valid_o,
  input  logic        event_ready_i,
  output logic [2:0]  event_kind_o,
  output logic [7:0]  event_byte_o,
  output logic [15:0] window_width_o,
  output logic [15:0] window_height_o
);

  tnp_pkg::req_t   req;
  tnp_pkg::event_t ev_parse;
  tnp_pkg::event_t ev_out;
  logic            ev_parse_valid;
  logic            out_free;

  // input register: one byte request
  tnp_in_reg u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (rx_valid_i),
    .rx_ready_o (rx_ready_o),
    .rx_byte_i  (rx_byte_i),
    .out_free_i (out_free),
    .req_o      (req)
  );

  // phase tracking, body counting and window-size assembly
  tnp_fsm #(
    .BodyLimit (BodyLimit)
  ) u_fsm (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req),
    .ev_valid_o (ev_parse_valid),
    .ev_o       (ev_parse)
  );

  // result register; loads on every parse step, valid only when an event
  tnp_out_reg u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (req.fire),
    .ev_valid_i    (ev_parse_valid),
    .ev_i          (ev_parse),
    .free_o        (out_free),
    .event_valid_o (event_valid_o),
    .event_ready_i (event_ready_i),
    .ev_o          (ev_out)
  );

  assign event_kind_o    = ev_out.kind;
  assign event_byte_o    = ev_out.ev_byte;
  assign window_width_o  = ev_out.width;
  assign window_height_o = ev_out.height;

endmodule

// ===== rtl/tnp_checker.sv =====
// ----------------------------------------------------------------------------
// tnp_checker: port-level checks for the telnet option parser
// Watches the event channel for held payloads and consistent event fields.
// ----------------------------------------------------------------------------
module tnp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        event_valid_o,
  input logic        event_ready_i,
  input logic [2:0]  event_kind_o,
  input logic [7:0]  event_byte_o,
  input logic [15:0] window_width_o,
  input logic [15:0] window_height_o
);

  // a stalled event keeps its payload
  a_ev_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    event_valid_o && !event_ready_i |=>
      event_valid_o && $stable(event_kind_o) && $stable(event_byte_o) &&
      $stable(window_width_o) && $stable(window_height_o))
    else $error("event payload changed while stalled");

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    event_valid_o |->
      (event_kind_o == tnp_pkg::EV_CHAR || event_kind_o == tnp_pkg::EV_CMD ||
       event_kind_o == tnp_pkg::EV_WILL || event_kind_o == tnp_pkg::EV_WONT ||
       event_kind_o == tnp_pkg::EV_WINSZ))
    else $error("event kind out of range");

  a_char_printable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    event_valid_o && event_kind_o == tnp_pkg::EV_CHAR |->
      event_byte_o >= tnp_pkg::PrintLo && event_byte_o <= tnp_pkg::PrintHi)
    else $error("character event with non-printable byte");

  a_size_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    event_valid_o && event_kind_o != tnp_pkg::EV_WINSZ |->
      window_width_o == 16'd0 && window_height_o == 16'd0)
    else $error("window fields set on a non-window event");

  a_winsz_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    event_valid_o && event_kind_o == tnp_pkg::EV_WINSZ |-> event_byte_o == 8'd0)
    else $error("window event carries a byte");

endmodule

bind telnet_option_parser tnp_checker u_tnp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .event_valid_o   (event_valid_o),
  .event_ready_i   (event_ready_i),
  .event_kind_o    (event_kind_o),
  .event_byte_o    (event_byte_o),
  .window_width_o  (window_width_o),
  .window_height_o (window_height_o)
);
